[rtl/scpb_pkg.sv]
// scpb_pkg: shared types and constants for the star color pixel blend core
// register indexes, curve coefficients, fixed-point limits, pipeline stage records
// no dependencies
package scpb_pkg;

    // configuration register indexes
    localparam int unsigned CFG_INDEX_W = 3;
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_DIM_MAGNITUDE   = 3'd0,
        CFG_BRIGHTNESS_GAIN = 3'd1,
        CFG_ALPHA_BOOST     = 3'd2,
        CFG_FRAME_WIDTH     = 3'd3,
        CFG_FRAME_HEIGHT    = 3'd4
    } cfg_index_t;
    localparam int unsigned CFG_DATA_W = 17;

    // register reset values
    localparam logic signed [12:0] DIM_MAGNITUDE_RST   = 13'sd3866;
    localparam logic signed [16:0] BRIGHTNESS_GAIN_RST = -17'sd5904;
    localparam logic [8:0]         ALPHA_BOOST_RST     = 9'd0;
    localparam logic [15:0]        FRAME_WIDTH_RST     = 16'd8192;
    localparam logic [15:0]        FRAME_HEIGHT_RST    = 16'd4096;

    // fixed-point limits: alpha is Q16, a channel is 10240 * byte value
    localparam logic [16:0]        ALPHA_ONE = 17'd65536;
    localparam logic signed [27:0] CHAN_ONE  = 28'sd2611200;
    localparam logic [21:0]        CHAN_MAX  = 22'd2611200;

    // color curve breakpoints on the Q10 color index
    localparam logic signed [12:0] RED_KNEE      = 13'sd512;
    localparam logic signed [12:0] GREEN_KNEE_LO = 13'sd409;
    localparam logic signed [12:0] GREEN_KNEE_HI = 13'sd1740;
    localparam logic signed [12:0] BLUE_KNEE_LO  = 13'sd512;
    localparam logic signed [12:0] BLUE_KNEE_HI  = 13'sd1740;

    // color curve slopes and offsets, scaled so the result is 10240 * byte
    localparam logic signed [27:0] RED_SLOPE      = 28'sd1100;
    localparam logic signed [27:0] RED_OFFSET     = 28'sd2048000;
    localparam logic signed [27:0] GREEN_SLOPE_A  = 28'sd944;
    localparam logic signed [27:0] GREEN_OFFSET_A = 28'sd2224128;
    localparam logic signed [27:0] GREEN_SLOPE_B  = -28'sd423;
    localparam logic signed [27:0] GREEN_OFFSET_B = 28'sd2785280;
    localparam logic signed [27:0] GREEN_SLOPE_C  = -28'sd6670;
    localparam logic signed [27:0] GREEN_OFFSET_C = 28'sd13649920;
    localparam logic signed [27:0] BLUE_SLOPE_B   = -28'sd2000;
    localparam logic signed [27:0] BLUE_OFFSET_B  = 28'sd3072000;
    localparam logic signed [27:0] BLUE_SLOPE_C   = -28'sd5000;
    localparam logic signed [27:0] BLUE_OFFSET_C  = 28'sd10240000;

    // division by 5 for quotients below 2048: (q * 13108) >> 16
    localparam logic [13:0] DIV5_RECIP = 14'd13108;

    // stage 1: raw products and curve values
    typedef struct packed {
        logic signed [30:0] bright_prod;
        logic signed [27:0] red_raw;
        logic signed [27:0] green_raw;
        logic signed [27:0] blue_raw;
        logic               in_frame;
        logic signed [16:0] x;
        logic signed [16:0] y;
        logic [7:0]         old_red;
        logic [7:0]         old_green;
        logic [7:0]         old_blue;
        logic [7:0]         old_alpha;
    } stage1_t;

    // stage 2: clamped alpha and channels
    typedef struct packed {
        logic [16:0]        alpha;
        logic [21:0]        red;
        logic [21:0]        green;
        logic [21:0]        blue;
        logic               in_frame;
        logic signed [16:0] x;
        logic signed [16:0] y;
        logic [7:0]         old_red;
        logic [7:0]         old_green;
        logic [7:0]         old_blue;
        logic [7:0]         old_alpha;
    } stage2_t;

    // stage 3: alpha-weighted products
    typedef struct packed {
        logic [37:0]        red_prod;
        logic [37:0]        green_prod;
        logic [37:0]        blue_prod;
        logic [23:0]        alpha_prod;
        logic               in_frame;
        logic signed [16:0] x;
        logic signed [16:0] y;
        logic [7:0]         old_red;
        logic [7:0]         old_green;
        logic [7:0]         old_blue;
        logic [7:0]         old_alpha;
    } stage3_t;

    // saturating byte add
    function automatic logic [7:0] add_sat(input logic [7:0] old, input logic [7:0] add);
        logic [8:0] sum;
        sum = {1'b0, old} + {1'b0, add};
        return sum[8] ? 8'hFF : sum[7:0];
    endfunction

    // channel product to byte: floor(p / (5 * 2^27))
    function automatic logic [7:0] chan_to_byte(input logic [37:0] p);
        logic [10:0] q;
        logic [24:0] m;
        q = p[37:27];
        m = {14'd0, q} * {11'd0, DIV5_RECIP};
        return m[23:16];
    endfunction

endpackage

[rtl/star_color_pixel_blend_core.sv]
// star_color_pixel_blend_core: top level of the star color pixel blend
// four-stage pipeline: brightness and curves, clamping, weighting, blend and output
// depends on scpb_pkg
//
// Usage
//   Input channel: in_valid / in_stall with one star transaction per cycle while in_stall
//   is low (color index, magnitude, target pixel coordinate and the pixel's current RGBA bytes).
//   Output channel: out_valid / out_stall with the blended RGBA bytes, the passed-through
//   coordinate and write_enable, low when the pixel lies off frame (bytes are then zero).
//   Configuration: cfg_write with cfg_index and cfg_data, to be written only while idle;
//   the block does not enforce this; indexes beyond the frame height register are ignored.
// Timing
//   out_valid rises when the transaction reaches the fourth register stage; with no stall
//   one transaction is taken every cycle, since each of the four register stages moves
//   whenever the next one moves. When the receiver stalls, each stage holding a
//   transaction waits and empty stages keep filling, so in_stall rises only once all
//   four stages are full.
// Reset
//   rst_n clears all stage valid bits and loads the configuration defaults.
module star_color_pixel_blend_core (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // configuration write port
    input  logic                                   cfg_write,
    input  logic [scpb_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [scpb_pkg::CFG_DATA_W-1:0]        cfg_data,
    // input channel
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [12:0]                     color_index,
    input  logic signed [12:0]                     star_magnitude,
    input  logic signed [16:0]                     pixel_x,
    input  logic signed [16:0]                     pixel_y,
    input  logic [7:0]                             old_red,
    input  logic [7:0]                             old_green,
    input  logic [7:0]                             old_blue,
    input  logic [7:0]                             old_alpha,
    // output channel
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [16:0]                     out_x,
    output logic signed [16:0]                     out_y,
    output logic                                   write_enable,
    output logic [7:0]                             new_red,
    output logic [7:0]                             new_green,
    output logic [7:0]                             new_blue,
    output logic [7:0]                             new_alpha
);

    // configuration registers
    logic signed [12:0] dim_magnitude_reg;
    logic signed [16:0] brightness_gain_reg;
    logic [8:0]         alpha_boost_reg;
    logic [15:0]        frame_width_reg;
    logic [15:0]        frame_height_reg;

    // pipeline registers
    logic              s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    scpb_pkg::stage1_t s1_reg, s1_next;
    scpb_pkg::stage2_t s2_reg, s2_next;
    scpb_pkg::stage3_t s3_reg, s3_next;

    logic signed [16:0] out_x_reg, out_y_reg;
    logic               write_enable_reg;
    logic [7:0]         new_red_reg, new_green_reg, new_blue_reg, new_alpha_reg;
    logic signed [16:0] out_x_next, out_y_next;
    logic               write_enable_next;
    logic [7:0]         new_red_next, new_green_next, new_blue_next, new_alpha_next;

    // stage advance enables
    logic s1_en, s2_en, s3_en, s4_en;

    // stage 1 working signals
    logic signed [13:0] mag_diff;
    logic signed [27:0] ci_w;

    // stage 2 working signals
    logic signed [22:0] alpha_shift;
    logic [16:0]        alpha_clamped;
    logic [17:0]        alpha_boosted;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_magnitude_reg   <= scpb_pkg::DIM_MAGNITUDE_RST;
            brightness_gain_reg <= scpb_pkg::BRIGHTNESS_GAIN_RST;
            alpha_boost_reg     <= scpb_pkg::ALPHA_BOOST_RST;
            frame_width_reg     <= scpb_pkg::FRAME_WIDTH_RST;
            frame_height_reg    <= scpb_pkg::FRAME_HEIGHT_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                scpb_pkg::CFG_DIM_MAGNITUDE:   dim_magnitude_reg   <= cfg_data[12:0];
                scpb_pkg::CFG_BRIGHTNESS_GAIN: brightness_gain_reg <= cfg_data[16:0];
                scpb_pkg::CFG_ALPHA_BOOST:     alpha_boost_reg     <= cfg_data[8:0];
                scpb_pkg::CFG_FRAME_WIDTH:     frame_width_reg     <= cfg_data[15:0];
                scpb_pkg::CFG_FRAME_HEIGHT:    frame_height_reg    <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // stall chain: a stage moves when it is empty or the next one moves
    assign s4_en    = !s4_valid_reg || !out_stall;
    assign s3_en    = !s3_valid_reg || s4_en;
    assign s2_en    = !s2_valid_reg || s3_en;
    assign s1_en    = !s1_valid_reg || s2_en;
    assign in_stall = !s1_en;

    // stage 1: brightness product, raw curves, bounds check
    always_comb
    begin
        mag_diff = 14'(star_magnitude) - 14'(dim_magnitude_reg);
        ci_w     = 28'(color_index);

        s1_next.bright_prod = 31'(mag_diff) * 31'(brightness_gain_reg);

        if (color_index < scpb_pkg::RED_KNEE)
            s1_next.red_raw = scpb_pkg::RED_SLOPE * ci_w + scpb_pkg::RED_OFFSET;
        else
            s1_next.red_raw = scpb_pkg::CHAN_ONE;

        if (color_index <= scpb_pkg::GREEN_KNEE_LO)
            s1_next.green_raw = scpb_pkg::GREEN_SLOPE_A * ci_w + scpb_pkg::GREEN_OFFSET_A;
        else if (color_index <= scpb_pkg::GREEN_KNEE_HI)
            s1_next.green_raw = scpb_pkg::GREEN_SLOPE_B * ci_w + scpb_pkg::GREEN_OFFSET_B;
        else
            s1_next.green_raw = scpb_pkg::GREEN_SLOPE_C * ci_w + scpb_pkg::GREEN_OFFSET_C;

        if (color_index < scpb_pkg::BLUE_KNEE_LO)
            s1_next.blue_raw = scpb_pkg::CHAN_ONE;
        else if (color_index <= scpb_pkg::BLUE_KNEE_HI)
            s1_next.blue_raw = scpb_pkg::BLUE_SLOPE_B * ci_w + scpb_pkg::BLUE_OFFSET_B;
        else
            s1_next.blue_raw = scpb_pkg::BLUE_SLOPE_C * ci_w + scpb_pkg::BLUE_OFFSET_C;

        s1_next.in_frame = !pixel_x[16] && !pixel_y[16] &&
                           (pixel_x[15:0] < frame_width_reg) &&
                           (pixel_y[15:0] < frame_height_reg);
        s1_next.x         = pixel_x;
        s1_next.y         = pixel_y;
        s1_next.old_red   = old_red;
        s1_next.old_green = old_green;
        s1_next.old_blue  = old_blue;
        s1_next.old_alpha = old_alpha;
    end

    // stage 2: alpha floor shift, clamp and boost; channel clamp
    always_comb
    begin
        alpha_shift = 23'(s1_reg.bright_prod >>> 8);
        if (alpha_shift < 0)
            alpha_clamped = '0;
        else if (alpha_shift > 23'sd65536)
            alpha_clamped = scpb_pkg::ALPHA_ONE;
        else
            alpha_clamped = alpha_shift[16:0];

        alpha_boosted = {1'b0, alpha_clamped} + {1'b0, alpha_boost_reg, 8'd0};
        if (alpha_boosted > {1'b0, scpb_pkg::ALPHA_ONE})
            s2_next.alpha = scpb_pkg::ALPHA_ONE;
        else
            s2_next.alpha = alpha_boosted[16:0];

        if (s1_reg.red_raw < 0)
            s2_next.red = '0;
        else if (s1_reg.red_raw > scpb_pkg::CHAN_ONE)
            s2_next.red = scpb_pkg::CHAN_MAX;
        else
            s2_next.red = s1_reg.red_raw[21:0];

        if (s1_reg.green_raw < 0)
            s2_next.green = '0;
        else if (s1_reg.green_raw > scpb_pkg::CHAN_ONE)
            s2_next.green = scpb_pkg::CHAN_MAX;
        else
            s2_next.green = s1_reg.green_raw[21:0];

        if (s1_reg.blue_raw < 0)
            s2_next.blue = '0;
        else if (s1_reg.blue_raw > scpb_pkg::CHAN_ONE)
            s2_next.blue = scpb_pkg::CHAN_MAX;
        else
            s2_next.blue = s1_reg.blue_raw[21:0];

        s2_next.in_frame  = s1_reg.in_frame;
        s2_next.x         = s1_reg.x;
        s2_next.y         = s1_reg.y;
        s2_next.old_red   = s1_reg.old_red;
        s2_next.old_green = s1_reg.old_green;
        s2_next.old_blue  = s1_reg.old_blue;
        s2_next.old_alpha = s1_reg.old_alpha;
    end

    // stage 3: weight channels by alpha
    always_comb
    begin
        s3_next.red_prod   = {21'd0, s2_reg.alpha} * {16'd0, s2_reg.red};
        s3_next.green_prod = {21'd0, s2_reg.alpha} * {16'd0, s2_reg.green};
        s3_next.blue_prod  = {21'd0, s2_reg.alpha} * {16'd0, s2_reg.blue};
        s3_next.alpha_prod = {7'd0, s2_reg.alpha} * 24'd255;
        s3_next.in_frame   = s2_reg.in_frame;
        s3_next.x          = s2_reg.x;
        s3_next.y          = s2_reg.y;
        s3_next.old_red    = s2_reg.old_red;
        s3_next.old_green  = s2_reg.old_green;
        s3_next.old_blue   = s2_reg.old_blue;
        s3_next.old_alpha  = s2_reg.old_alpha;
    end

    // stage 4: scale to bytes, saturating blend, off-frame zeroing
    always_comb
    begin
        out_x_next        = s3_reg.x;
        out_y_next        = s3_reg.y;
        write_enable_next = s3_reg.in_frame;
        if (s3_reg.in_frame)
        begin
            new_red_next   = scpb_pkg::add_sat(s3_reg.old_red,
                                               scpb_pkg::chan_to_byte(s3_reg.red_prod));
            new_green_next = scpb_pkg::add_sat(s3_reg.old_green,
                                               scpb_pkg::chan_to_byte(s3_reg.green_prod));
            new_blue_next  = scpb_pkg::add_sat(s3_reg.old_blue,
                                               scpb_pkg::chan_to_byte(s3_reg.blue_prod));
            new_alpha_next = scpb_pkg::add_sat(s3_reg.old_alpha, s3_reg.alpha_prod[23:16]);
        end
        else
        begin
            new_red_next   = '0;
            new_green_next = '0;
            new_blue_next  = '0;
            new_alpha_next = '0;
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_en) s1_valid_reg <= in_valid;
            if (s2_en) s2_valid_reg <= s1_valid_reg;
            if (s3_en) s3_valid_reg <= s2_valid_reg;
            if (s4_en) s4_valid_reg <= s3_valid_reg;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s1_en) s1_reg <= s1_next;
        if (s2_en) s2_reg <= s2_next;
        if (s3_en) s3_reg <= s3_next;
        if (s4_en)
        begin
            out_x_reg        <= out_x_next;
            out_y_reg        <= out_y_next;
            write_enable_reg <= write_enable_next;
            new_red_reg      <= new_red_next;
            new_green_reg    <= new_green_next;
            new_blue_reg     <= new_blue_next;
            new_alpha_reg    <= new_alpha_next;
        end
    end

    assign out_valid    = s4_valid_reg;
    assign out_x        = out_x_reg;
    assign out_y        = out_y_reg;
    assign write_enable = write_enable_reg;
    assign new_red      = new_red_reg;
    assign new_green    = new_green_reg;
    assign new_blue     = new_blue_reg;
    assign new_alpha    = new_alpha_reg;

    // input stalls only when every stage is full and the output is held
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && s2_valid_reg && s3_valid_reg && out_valid && out_stall))
        else $error("input stalled while pipeline has room");

    // off-frame transactions carry zero bytes
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !write_enable) |->
            (new_red == 8'd0 && new_green == 8'd0 && new_blue == 8'd0 && new_alpha == 8'd0))
        else $error("off-frame transaction with nonzero bytes");

    // clamped alpha never exceeds one
    assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> (s2_reg.alpha <= scpb_pkg::ALPHA_ONE))
        else $error("alpha above one after clamp");

    // a held stage keeps its transaction when the next stage cannot take it
    assert property (@(posedge clk) disable iff (!rst_n)
        (s3_valid_reg && !s3_en) |=> (s3_valid_reg && $stable(s3_reg)))
        else $error("stalled stage lost its transaction");

endmodule

[tb/tb_star_color_pixel_blend_core.sv]
// tb_star_color_pixel_blend_core: self-checking testbench for the star color pixel blend core
// a table of directed stars, then random stars over several register settings, with stalls
// depends on scpb_pkg and star_color_pixel_blend_core
module tb_star_color_pixel_blend_core;
    timeunit 1ns;
    timeprecision 1ps;

    // configuration port words
    typedef logic [scpb_pkg::CFG_INDEX_W-1:0] cfg_addr_t;
    typedef logic [scpb_pkg::CFG_DATA_W-1:0]  cfg_word_t;

    // one star transaction on the input side
    typedef struct packed {
        logic signed [12:0] color_index;
        logic signed [12:0] star_magnitude;
        logic signed [16:0] pixel_x;
        logic signed [16:0] pixel_y;
        logic [7:0]         old_red;
        logic [7:0]         old_green;
        logic [7:0]         old_blue;
        logic [7:0]         old_alpha;
    } star_t;

    // one blended pixel transaction on the output side
    typedef struct packed {
        logic signed [16:0] out_x;
        logic signed [16:0] out_y;
        logic               write_enable;
        logic [7:0]         new_red;
        logic [7:0]         new_green;
        logic [7:0]         new_blue;
        logic [7:0]         new_alpha;
    } blend_t;

    // register contents, held as the block holds them
    typedef struct packed {
        logic signed [12:0] dim;
        logic signed [16:0] gain;
        logic [8:0]         boost;
        logic [15:0]        width;
        logic [15:0]        height;
    } blend_cfg_t;

    // directed stimulus row; known rows carry a hand-computed result
    typedef struct packed {
        star_t  star;
        logic   known;
        blend_t want;
    } directed_row_t;

    localparam longint ALPHA_FULL     = 65536;
    localparam longint CHANNEL_FULL   = 2611200;
    localparam longint CHANNEL_DIV    = 65536 * 10240;
    localparam int     IDLE_PCT       = 23;
    localparam int     HOLD_OFF_CYCLES = 250;
    localparam int     TAIL_CYCLES    = 16;
    localparam int     CYCLE_LIMIT    = 100000;
    localparam int     ERROR_PRINT_CAP = 60;
    localparam cfg_addr_t FIRST_UNMAPPED_INDEX = 3'd5;

    localparam blend_cfg_t RESET_SETTING = '{3866, -5904, 0, 8192, 4096};
    localparam blend_t     NO_EXPECTATION = '0;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_write;
    cfg_addr_t              cfg_index;
    cfg_word_t              cfg_data;
    logic                   in_valid;
    logic                   in_stall;
    logic signed [12:0]     color_index;
    logic signed [12:0]     star_magnitude;
    logic signed [16:0]     pixel_x;
    logic signed [16:0]     pixel_y;
    logic [7:0]             old_red;
    logic [7:0]             old_green;
    logic [7:0]             old_blue;
    logic [7:0]             old_alpha;
    logic                   out_valid;
    logic                   out_stall;
    logic signed [16:0]     out_x;
    logic signed [16:0]     out_y;
    logic                   write_enable;
    logic [7:0]             new_red;
    logic [7:0]             new_green;
    logic [7:0]             new_blue;
    logic [7:0]             new_alpha;

    blend_t     pending_pixels[$];
    blend_cfg_t active_cfg = RESET_SETTING;
    int         sender_idle_pct = IDLE_PCT;
    int         rx_idle_pct = IDLE_PCT;
    bit         hold_off_req = 1'b0;
    int         cycle_count = 0;
    int         error_count = 0;
    int         stars_sent = 0;
    int         pixels_written = 0;
    int         pixels_skipped = 0;
    int         settings_used = 1;

    // extremes of the register space, degenerate frames and boost above one
    blend_cfg_t fixed_settings [5] = '{
        '{-2048,  65535,   0, 65535, 65535},
        '{ 4095, -65536, 256,     2,     1},
        '{    0,   -256, 511,   640,   480},
        '{ 1000,    300, 100,     0,   100},
        '{ 2000,  -3000,   1,    64,     0}
    };

    // directed stars under the reset settings (8192 x 4096 frame)
    directed_row_t directed_rows [21] = '{
        // brightest star, alpha saturated, index zero
        '{'{0, -2048, 0, 0, 0, 0, 0, 0}, 1'b1, '{0, 0, 1, 200, 217, 255, 255}},
        // far in-frame corner, every byte saturates
        '{'{0, -2048, 8191, 4095, 255, 255, 255, 255}, 1'b1,
          '{8191, 4095, 1, 255, 255, 255, 255}},
        // bluest and reddest index at full alpha
        '{'{-4096, -2048, 100, 200, 0, 0, 0, 0}, 1'b1, '{100, 200, 1, 0, 0, 255, 255}},
        '{'{4095, -2048, 5, 6, 0, 0, 0, 0}, 1'b1, '{5, 6, 1, 255, 0, 0, 255}},
        // fainter than the dim limit and exactly at it: pixel unchanged
        '{'{0, 4095, 1, 1, 12, 34, 56, 78}, 1'b1, '{1, 1, 1, 12, 34, 56, 78}},
        '{'{-1, 3866, 2, 3, 1, 2, 3, 4}, 1'b1, '{2, 3, 1, 1, 2, 3, 4}},
        // off frame on each side, bytes forced to zero
        '{'{0, -2048, -1, 0, 9, 9, 9, 9}, 1'b1, '{-1, 0, 0, 0, 0, 0, 0}},
        '{'{0, -2048, 8192, 0, 9, 9, 9, 9}, 1'b1, '{8192, 0, 0, 0, 0, 0, 0}},
        '{'{0, -2048, 0, 4096, 9, 9, 9, 9}, 1'b1, '{0, 4096, 0, 0, 0, 0, 0}},
        '{'{0, -2048, -65536, -65536, 9, 9, 9, 9}, 1'b1,
          '{-65536, -65536, 0, 0, 0, 0, 0}},
        '{'{0, -2048, 65535, 65535, 255, 255, 255, 255}, 1'b1,
          '{65535, 65535, 0, 0, 0, 0, 0}},
        // curve knees on either side
        '{'{511, 1000, 10, 10, 0, 0, 0, 0}, 1'b0, NO_EXPECTATION},
        '{'{512, 1000, 10, 11, 0, 0, 0, 0}, 1'b0, NO_EXPECTATION},
        '{'{409, 1000, 10, 12, 0, 0, 0, 0}, 1'b0, NO_EXPECTATION},
        '{'{410, 1000, 10, 13, 0, 0, 0, 0}, 1'b0, NO_EXPECTATION},
        '{'{1740, 1000, 10, 14, 0, 0, 0, 0}, 1'b0, NO_EXPECTATION},
        '{'{1741, 1000, 10, 15, 0, 0, 0, 0}, 1'b0, NO_EXPECTATION},
        // full alpha, then partial alpha at various magnitudes
        '{'{-1, 0, 20, 20, 5, 5, 5, 5}, 1'b0, NO_EXPECTATION},
        '{'{700, 3000, 8191, 0, 200, 200, 200, 200}, 1'b0, NO_EXPECTATION},
        '{'{1500, 2000, 4000, 2000, 128, 64, 32, 16}, 1'b0, NO_EXPECTATION},
        '{'{-800, 3800, 0, 4095, 250, 250, 250, 250}, 1'b0, NO_EXPECTATION}
    };

    star_color_pixel_blend_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .color_index    (color_index),
        .star_magnitude (star_magnitude),
        .pixel_x        (pixel_x),
        .pixel_y        (pixel_y),
        .old_red        (old_red),
        .old_green      (old_green),
        .old_blue       (old_blue),
        .old_alpha      (old_alpha),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_x          (out_x),
        .out_y          (out_y),
        .write_enable   (write_enable),
        .new_red        (new_red),
        .new_green      (new_green),
        .new_blue       (new_blue),
        .new_alpha      (new_alpha)
    );

    // 4 ns clock
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_pixels.size());
            $display("tb_star_color_pixel_blend_core NOT OK");
            $finish;
        end
    end

    function automatic longint clamp_range(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic logic [7:0] sat_byte(input logic [7:0] old, input longint add);
        longint sum;
        sum = longint'(old) + add;
        return (sum > 255) ? 8'hFF : sum[7:0];
    endfunction

    // expected blended pixel for one star under the current registers
    function automatic blend_t predict_blend(input star_t s);
        blend_t r;
        longint ci;
        longint alpha;
        longint red;
        longint green;
        longint blue;
        logic   in_frame;
        ci = s.color_index;

        // opacity from magnitude, floor of the Q8 product, clamped before and after the boost
        alpha = ((longint'(s.star_magnitude) - longint'(active_cfg.dim))
                 * longint'(active_cfg.gain)) >>> 8;
        alpha = clamp_range(alpha, 0, ALPHA_FULL);
        alpha = clamp_range(alpha + longint'(active_cfg.boost) * 256, 0, ALPHA_FULL);

        // piecewise-linear color curves, scaled by 10240 per byte unit
        if (ci < 512)
            red = clamp_range(1100 * ci + 2000 * 1024, 0, CHANNEL_FULL);
        else
            red = CHANNEL_FULL;
        if (10 * ci < 4096)
            green = 944 * ci + 2172 * 1024;
        else if (10 * ci <= 17408)
            green = -423 * ci + 2720 * 1024;
        else
            green = -6670 * ci + 13330 * 1024;
        green = clamp_range(green, 0, CHANNEL_FULL);
        if (ci < 512)
            blue = CHANNEL_FULL;
        else if (10 * ci < 17408)
            blue = clamp_range(-2000 * ci + 3000 * 1024, 0, CHANNEL_FULL);
        else
            blue = clamp_range(-5000 * ci + 10000 * 1024, 0, CHANNEL_FULL);

        in_frame = (s.pixel_x >= 0) && (s.pixel_y >= 0) &&
                   (longint'(s.pixel_x) < longint'(active_cfg.width)) &&
                   (longint'(s.pixel_y) < longint'(active_cfg.height));

        r = '0;
        r.out_x = s.pixel_x;
        r.out_y = s.pixel_y;
        r.write_enable = in_frame;
        if (in_frame)
        begin
            r.new_red   = sat_byte(s.old_red, alpha * red / CHANNEL_DIV);
            r.new_green = sat_byte(s.old_green, alpha * green / CHANNEL_DIV);
            r.new_blue  = sat_byte(s.old_blue, alpha * blue / CHANNEL_DIV);
            r.new_alpha = sat_byte(s.old_alpha, alpha * 255 / ALPHA_FULL);
        end
        return r;
    endfunction

    // coordinate mostly in the frame, sometimes on its edges, sometimes anywhere
    function automatic logic signed [16:0] pick_coord(input longint span);
        int unsigned pick;
        longint      v;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            v = (span > 0) ? longint'($urandom_range(0, int'(span - 1))) : 0;
        else if (pick < 85)
        begin
            case ($urandom_range(0, 3))
                0:       v = -1;
                1:       v = 0;
                2:       v = span - 1;
                default: v = span;
            endcase
        end
        else
            v = longint'($urandom_range(0, 131071)) - 65536;
        return v[16:0];
    endfunction

    function automatic star_t random_star();
        star_t  s;
        longint band;
        longint mag;
        longint gain_abs;
        s.color_index = ($urandom_range(0, 99) < 30) ? 13'($urandom_range(0, 2047))
                                                     : 13'($urandom);
        s.pixel_x = pick_coord(longint'(active_cfg.width));
        s.pixel_y = pick_coord(longint'(active_cfg.height));

        // magnitude either anywhere or within the band where alpha ramps
        gain_abs = longint'(active_cfg.gain);
        if (gain_abs < 0)
            gain_abs = -gain_abs;
        band = clamp_range(16777216 / (gain_abs + 1) + 8, 8, 6143);
        if ($urandom_range(0, 99) < 40)
            mag = longint'($urandom_range(0, 6143)) - 2048;
        else
            mag = longint'(active_cfg.dim) + longint'($urandom_range(0, int'(2 * band))) - band;
        s.star_magnitude = 13'(clamp_range(mag, -2048, 4095));

        case ($urandom_range(0, 9))
            0:       {s.old_red, s.old_green, s.old_blue, s.old_alpha} = '1;
            1:       {s.old_red, s.old_green, s.old_blue, s.old_alpha} = '0;
            default: {s.old_red, s.old_green, s.old_blue, s.old_alpha} = $urandom;
        endcase
        return s;
    endfunction

    task automatic flag_pixel_error(input string what, input longint got, input longint want);
        error_count++;
        // cap the printout on a badly broken block, keep counting
        if (error_count <= ERROR_PRINT_CAP)
            $display("mismatch at cycle %0d: %s got %0d expected %0d",
                     cycle_count, what, got, want);
    endtask

    // offer one star transaction and record its result once accepted
    task automatic send_star(input star_t s, input blend_t want);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        {color_index, star_magnitude, pixel_x, pixel_y,
         old_red, old_green, old_blue, old_alpha} <= s;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_pixels.push_back(want);
        stars_sent++;
        @(negedge clk);
    endtask

    task automatic run_random(input int count);
        star_t s;
        repeat (count)
        begin
            s = random_star();
            send_star(s, predict_blend(s));
        end
    endtask

    // stop offering and wait for every outstanding pixel
    task automatic drain_pixels();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_pixels.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input cfg_addr_t idx, input cfg_word_t data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        case (idx)
            scpb_pkg::CFG_DIM_MAGNITUDE:   active_cfg.dim    = data[12:0];
            scpb_pkg::CFG_BRIGHTNESS_GAIN: active_cfg.gain   = data[16:0];
            scpb_pkg::CFG_ALPHA_BOOST:     active_cfg.boost  = data[8:0];
            scpb_pkg::CFG_FRAME_WIDTH:     active_cfg.width  = data[15:0];
            scpb_pkg::CFG_FRAME_HEIGHT:    active_cfg.height = data[15:0];
            default:                       ;
        endcase
    endtask

    // load all registers; unused upper data bits carry noise, plus a write to an unmapped index
    task automatic apply_config(input blend_cfg_t c);
        cfg_word_t raw;
        raw = cfg_word_t'($urandom);
        raw[12:0] = c.dim;
        write_reg(scpb_pkg::CFG_DIM_MAGNITUDE, raw);
        write_reg(scpb_pkg::CFG_BRIGHTNESS_GAIN, c.gain);
        raw = cfg_word_t'($urandom);
        raw[8:0] = c.boost;
        write_reg(scpb_pkg::CFG_ALPHA_BOOST, raw);
        write_reg(cfg_addr_t'(FIRST_UNMAPPED_INDEX + $urandom_range(0, 2)),
                  cfg_word_t'($urandom));
        raw = cfg_word_t'($urandom);
        raw[15:0] = c.width;
        write_reg(scpb_pkg::CFG_FRAME_WIDTH, raw);
        raw = cfg_word_t'($urandom);
        raw[15:0] = c.height;
        write_reg(scpb_pkg::CFG_FRAME_HEIGHT, raw);
        cfg_write <= 1'b0;
        settings_used++;
    endtask

    // receiver: random stalls, or a long hold-off on request
    initial
    begin : receiver
        int hold_left;
        hold_left = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
        end
    end

    // compare each accepted pixel with the oldest outstanding one
    always @(posedge clk)
    begin : result_check
        blend_t oldest;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_pixels.size() == 0)
                flag_pixel_error("unexpected transaction, out_x", out_x, 0);
            else
            begin
                oldest = pending_pixels.pop_front();
                if (out_x !== oldest.out_x)
                    flag_pixel_error("out_x", out_x, oldest.out_x);
                if (out_y !== oldest.out_y)
                    flag_pixel_error("out_y", out_y, oldest.out_y);
                if (write_enable !== oldest.write_enable)
                    flag_pixel_error("write_enable", write_enable, oldest.write_enable);
                if (new_red !== oldest.new_red)
                    flag_pixel_error("new_red", new_red, oldest.new_red);
                if (new_green !== oldest.new_green)
                    flag_pixel_error("new_green", new_green, oldest.new_green);
                if (new_blue !== oldest.new_blue)
                    flag_pixel_error("new_blue", new_blue, oldest.new_blue);
                if (new_alpha !== oldest.new_alpha)
                    flag_pixel_error("new_alpha", new_alpha, oldest.new_alpha);
                if (oldest.write_enable)
                    pixels_written++;
                else
                    pixels_skipped++;
            end
        end
    end

    // stimulus sequence
    initial
    begin : stimulus
        blend_cfg_t c;
        rst_n     <= 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= scpb_pkg::CFG_DIM_MAGNITUDE;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        {color_index, star_magnitude, pixel_x, pixel_y,
         old_red, old_green, old_blue, old_alpha} <= '0;
        repeat (6)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed stars under the reset settings
        foreach (directed_rows[i])
            send_star(directed_rows[i].star, directed_rows[i].known ?
                      directed_rows[i].want : predict_blend(directed_rows[i].star));
        run_random(150);

        // pause until the pipeline is empty, then fill it against a held-off receiver
        drain_pixels();
        hold_off_req = 1'b1;
        sender_idle_pct = 0;
        run_random(40);

        // long stretch with no idling on either side
        rx_idle_pct = 0;
        run_random(100);
        sender_idle_pct = IDLE_PCT;
        rx_idle_pct = IDLE_PCT;

        // extreme settings, then random ones
        foreach (fixed_settings[i])
        begin
            drain_pixels();
            apply_config(fixed_settings[i]);
            run_random(125);
        end
        repeat (3)
        begin
            c.dim    = 13'($urandom_range(0, 6143) - 2048);
            c.gain   = 17'($urandom);
            c.boost  = 9'($urandom);
            c.width  = 16'($urandom_range(2, 3000));
            c.height = 16'($urandom_range(1, 3000));
            drain_pixels();
            apply_config(c);
            run_random(125);
        end

        drain_pixels();
        repeat (TAIL_CYCLES)
            @(negedge clk);

        $display("%0d star transactions over %0d register settings", stars_sent, settings_used);
        $display("%0d pixels written in frame, %0d off frame, %0d mismatches",
                 pixels_written, pixels_skipped, error_count);
        if (error_count == 0)
            $display("tb_star_color_pixel_blend_core OK");
        else
            $display("tb_star_color_pixel_blend_core NOT OK");
        $finish;
    end

endmodule

[sim.f]
rtl/scpb_pkg.sv
rtl/star_color_pixel_blend_core.sv
tb/tb_star_color_pixel_blend_core.sv
